/* src/edi_tok_pkg.sv */
// Package with constants and codes shared by the EDIFACT byte tokenizer.
package edi_tok_pkg;

	localparam int unsigned CharW = 8;
	localparam int unsigned CfgIdxW = 2;
	localparam int unsigned TagLenW = 2;
	localparam int unsigned TagW = 3 * CharW;

	// Configuration register indexes.
	localparam logic [CfgIdxW-1:0] CFG_COMPONENT_SEP = 2'd0;
	localparam logic [CfgIdxW-1:0] CFG_ELEMENT_SEP   = 2'd1;
	localparam logic [CfgIdxW-1:0] CFG_RELEASE_CHAR  = 2'd2;
	localparam logic [CfgIdxW-1:0] CFG_SEGMENT_TERM  = 2'd3;

	// Reset values of the delimiter registers.
	localparam logic [CharW-1:0] RST_COMPONENT_SEP = 8'h3A;
	localparam logic [CharW-1:0] RST_ELEMENT_SEP   = 8'h2B;
	localparam logic [CharW-1:0] RST_RELEASE_CHAR  = 8'h3F;
	localparam logic [CharW-1:0] RST_SEGMENT_TERM  = 8'h27;

	localparam logic [CharW-1:0] CHAR_CR = 8'h0D;
	localparam logic [CharW-1:0] CHAR_LF = 8'h0A;

	// Control tags all begin with "UN".
	localparam logic [2*CharW-1:0] CTRL_PREFIX = 16'h554E;
	localparam logic [CharW-1:0] CTRL_A = 8'h41;
	localparam logic [CharW-1:0] CTRL_B = 8'h42;
	localparam logic [CharW-1:0] CTRL_H = 8'h48;
	localparam logic [CharW-1:0] CTRL_T = 8'h54;
	localparam logic [CharW-1:0] CTRL_Z = 8'h5A;

	localparam logic [TagLenW-1:0] TAG_FULL = 2'd3;

	// Style of a closed run.
	localparam logic [1:0] RUN_SEG_TAG  = 2'd0;
	localparam logic [1:0] RUN_CTRL_TAG = 2'd1;
	localparam logic [1:0] RUN_VALUE    = 2'd2;

	// Class of the current byte.
	localparam logic [1:0] BYTE_JOIN  = 2'd0;
	localparam logic [1:0] BYTE_SEP   = 2'd1;
	localparam logic [1:0] BYTE_LINE  = 2'd2;
	localparam logic [1:0] BYTE_FINAL = 2'd3;

endpackage

/* src/edifact_byte_tokenizer_top.sv */
// Output: the result beat of an accepted byte is on the output register in the next cycle.
// Throughput: one byte per cycle; the only storage between the sides is the result register,
// and a new byte is taken whenever that register is empty or is being read in the same cycle.
// Reset: arst_n clears the tokenizer state (start of segment, no escape, empty tag), empties
// the result register and loads the delimiter registers with : + ? and apostrophe.
module edifact_byte_tokenizer_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [edi_tok_pkg::CharW-1:0] text_byte,
	input  logic                          final_byte,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          closes_before,
	output logic [1:0]                    closed_style,
	output logic [1:0]                    byte_style,
	output logic                          tag_mode_after,
	input  logic                          cfg_we,
	input  logic [edi_tok_pkg::CfgIdxW-1:0] cfg_index,
	input  logic [edi_tok_pkg::CharW-1:0] cfg_wdata
);
	import edi_tok_pkg::*;

	logic [CharW-1:0]   component_sep_q;
	logic [CharW-1:0]   element_sep_q;
	logic [CharW-1:0]   release_char_q;
	logic [CharW-1:0]   segment_term_q;

	logic               escaped_q, escaped_d;
	logic               in_tag_q, in_tag_d;
	logic [TagW-1:0]    tag_chars_q, tag_chars_d;
	logic [TagLenW-1:0] tag_len_q, tag_len_d;

	logic               out_valid_q;
	logic               closes_q, closes_d;
	logic [1:0]         closed_q, closed_d;
	logic [1:0]         bstyle_q, bstyle_d;
	logic               tag_mode_q;

	logic               accept;
	logic               is_ctrl;
	logic [1:0]         run_style;
	logic [CharW-1:0]   tag_last;

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			component_sep_q <= RST_COMPONENT_SEP;
			element_sep_q   <= RST_ELEMENT_SEP;
			release_char_q  <= RST_RELEASE_CHAR;
			segment_term_q  <= RST_SEGMENT_TERM;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_COMPONENT_SEP: component_sep_q <= cfg_wdata;
				CFG_ELEMENT_SEP:   element_sep_q   <= cfg_wdata;
				CFG_RELEASE_CHAR:  release_char_q  <= cfg_wdata;
				CFG_SEGMENT_TERM:  segment_term_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Only a tag of exactly three letters can name a control segment.
	assign tag_last = tag_chars_q[CharW-1:0];
	assign is_ctrl  = (tag_len_q == TAG_FULL) && (tag_chars_q[TagW-1:CharW] == CTRL_PREFIX) &&
		((tag_last == CTRL_A) || (tag_last == CTRL_B) || (tag_last == CTRL_H) ||
		 (tag_last == CTRL_T) || (tag_last == CTRL_Z));

	always_comb begin
		if (!in_tag_q) begin
			run_style = RUN_VALUE;
		end else if (is_ctrl) begin
			run_style = RUN_CTRL_TAG;
		end else begin
			run_style = RUN_SEG_TAG;
		end
	end

	always_comb begin
		escaped_d   = escaped_q;
		in_tag_d    = in_tag_q;
		tag_chars_d = tag_chars_q;
		tag_len_d   = tag_len_q;
		closes_d    = 1'b0;
		closed_d    = RUN_SEG_TAG;
		bstyle_d    = BYTE_JOIN;

		if (escaped_q) begin
			escaped_d = 1'b0;
		end else if (text_byte == release_char_q) begin
			escaped_d = 1'b1;
		end else if ((text_byte == CHAR_CR) || (text_byte == CHAR_LF)) begin
			bstyle_d    = BYTE_LINE;
			in_tag_d    = 1'b1;
			tag_chars_d = '0;
			tag_len_d   = '0;
		end else if ((text_byte == element_sep_q) || (text_byte == component_sep_q)) begin
			closes_d = 1'b1;
			closed_d = run_style;
			bstyle_d = BYTE_SEP;
			in_tag_d = 1'b0;
		end else if (text_byte == segment_term_q) begin
			closes_d    = 1'b1;
			closed_d    = run_style;
			bstyle_d    = BYTE_SEP;
			in_tag_d    = 1'b1;
			tag_chars_d = '0;
			tag_len_d   = '0;
		end else if (in_tag_q) begin
			// A fourth letter turns the tag into value text.
			if (tag_len_q != TAG_FULL) begin
				tag_chars_d = {tag_chars_q[TagW-CharW-1:0], text_byte};
				tag_len_d   = tag_len_q + 1'b1;
			end else begin
				in_tag_d = 1'b0;
			end
		end

		// A final byte that would join the run closes it as a value run; every final byte rearms for a new text.
		if (final_byte) begin
			if (bstyle_d == BYTE_JOIN) begin
				bstyle_d = BYTE_FINAL;
				closed_d = RUN_VALUE;
			end
			escaped_d   = 1'b0;
			in_tag_d    = 1'b1;
			tag_chars_d = '0;
			tag_len_d   = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			escaped_q   <= 1'b0;
			in_tag_q    <= 1'b1;
			tag_chars_q <= '0;
			tag_len_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				escaped_q   <= escaped_d;
				in_tag_q    <= in_tag_d;
				tag_chars_q <= tag_chars_d;
				tag_len_q   <= tag_len_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			closes_q   <= closes_d;
			closed_q   <= closed_d;
			bstyle_q   <= bstyle_d;
			tag_mode_q <= in_tag_d;
		end
	end

	assign out_valid      = out_valid_q;
	assign closes_before  = closes_q;
	assign closed_style   = closed_q;
	assign byte_style     = bstyle_q;
	assign tag_mode_after = tag_mode_q;

`ifndef NO_ASSERTIONS
	a_final_closes_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (byte_style == BYTE_FINAL) |-> (closed_style == RUN_VALUE) && !closes_before)
		else $error("final close beat carries wrong run style");

	a_close_is_sep: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && closes_before |-> (byte_style == BYTE_SEP))
		else $error("run closed by a byte that is not a separator");

	a_final_rearms: assert property (@(posedge clk) disable iff (!arst_n)
		accept && final_byte |=> in_tag_q && !escaped_q && (tag_len_q == '0) && tag_mode_after)
		else $error("tokenizer did not rearm after the final byte");

	a_style_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (closed_style == RUN_SEG_TAG) || (closed_style == RUN_CTRL_TAG) ||
			(closed_style == RUN_VALUE))
		else $error("closed run style out of range");
`endif

endmodule
